@@ hw/rtl/fsge_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Falling sand grid engine package
// Request and result types, cell format and shared constants.
// ----------------------------------------------------------------------------
package fsge_pkg;

    // Default grid size.
    localparam int GRID_W_DEF = 64;
    localparam int GRID_H_DEF = 64;

    // Address width of one row bank at the default grid size.
    localparam int BANK_AW_DEF = $clog2(GRID_W_DEF) + $clog2(GRID_H_DEF) - 1;

    localparam int COLOR_W = 24;

    // Material modes. Any other code falls straight down only.
    localparam logic [1:0] MODE_SAND  = 2'd0;
    localparam logic [1:0] MODE_WATER = 2'd1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_PLACE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type            req_type;
        logic [5:0]           pos_x;
        logic [5:0]           pos_y;
        logic [COLOR_W-1:0]   color;
    } t_req;

    typedef struct packed {
        logic                 cell_occupied;
        logic [COLOR_W-1:0]   cell_color;
    } t_rsp;

    // One stored cell. An empty cell is all zeros.
    typedef struct packed {
        logic                 occ;
        logic [COLOR_W-1:0]   color;
    } t_cell;

    // The particle being visited and the five cells around it: the current row and
    // the row below, one column to each side.
    typedef struct packed {
        t_cell left;
        t_cell cur;
        t_cell right;
        t_cell below_left;
        t_cell below;
        t_cell below_right;
    } t_nbhd;

    typedef struct packed {
        logic cur_ok;
        logic left_ok;
        logic right_ok;
        logic skip;
    } t_visit_ctl;

endpackage
`default_nettype wire

@@ hw/rtl/falling_sand_grid_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Falling sand grid engine
// Grid of colored particles with place, clear, read and tick requests.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low, and
// every request returns exactly one result, shown on o_rsp for one cycle with
// o_rsp_valid high; the receiver cannot hold it off, so it must take it then.
// Only a read returns data; other requests answer with zeros. A place leaves
// the engine idle and the next request may follow at once. A read passes
// through the read state and answers from the registered bank output. A clear
// walks all 2**(clog2(GRID_W)+clog2(GRID_H)-1) addresses of both row banks,
// one address per cycle, 2048 at the default 64 by 64 grid. The same clearing
// pass runs after reset, and busy stays high through it; the material mode
// register can still be written then. A tick walks rows GRID_H-2 up to 0, one
// column per cycle; in each column step it reads one cell of the current row
// and one of the row below and writes back two cells that left the window.
// ----------------------------------------------------------------------------
module falling_sand_grid_engine
    import fsge_pkg::*;
#(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_req       i_req,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    output logic            o_rsp_valid,
    output t_rsp            o_rsp
);

    // Column, row and bank address widths. Even rows live in bank 0 and odd
    // rows in bank 1, so a row and the row below it never share a bank.
    localparam int X_W  = $clog2(GRID_W);
    localparam int Y_W  = $clog2(GRID_H);
    localparam int AW   = X_W + Y_W - 1;
    localparam int C_W  = $clog2(GRID_W + 3);

    localparam logic [C_W-1:0] COL_W     = C_W'(GRID_W);
    localparam logic [C_W-1:0] COL_W1    = C_W'(GRID_W + 1);
    localparam logic [C_W-1:0] COL_LAST  = C_W'(GRID_W + 2);
    localparam logic [Y_W-1:0] ROW_FIRST = Y_W'(GRID_H - 2);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_READ  = 4'b1000
    } t_state;

    t_state         r_state;
    logic [1:0]     r_mode;
    logic [AW-1:0]  r_clr;
    logic           r_owe;
    logic [Y_W-1:0] r_row;
    logic [C_W-1:0] r_col;
    logic           r_skip;
    logic           r_rd_bank;
    logic           r_rd_inside;
    logic           r_rsp_valid;
    t_rsp           r_rsp;

    // Sliding window over the current row and the row below.
    t_cell r_left, r_cur, r_below_left, r_below;

    logic accept;
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Request address decode.
    logic           req_inside;
    logic [X_W-1:0] req_x;
    logic [Y_W-1:0] req_y;
    logic [AW-1:0]  req_addr;

    assign req_inside = (int'(i_req.pos_x) < GRID_W) && (int'(i_req.pos_y) < GRID_H);
    assign req_x      = X_W'(i_req.pos_x);
    assign req_y      = Y_W'(i_req.pos_y);
    assign req_addr   = {req_y[Y_W-1:1], req_x};

    // Sweep timing. In column step c the cell in column c is read, the cell
    // in column c-1 arrives, the particle in column c-2 is visited and the
    // cells in column c-3 are written back.
    logic           in_valid;
    logic           cur_ok;
    logic           wr_en;
    logic [X_W-1:0] rd_col;
    logic [X_W-1:0] wr_col;
    logic [Y_W-1:0] row_below;

    assign in_valid  = (r_col != '0) && (r_col <= COL_W);
    assign cur_ok    = (r_col >= C_W'(2)) && (r_col <= COL_W1);
    assign wr_en     = (r_col >= C_W'(3));
    assign rd_col    = r_col[X_W-1:0];
    assign wr_col    = X_W'(r_col - C_W'(3));
    assign row_below = r_row + Y_W'(1);

    // Row banks.
    logic          bank_we    [2];
    logic [AW-1:0] bank_waddr [2];
    t_cell         bank_wdata [2];
    logic [AW-1:0] bank_raddr [2];
    t_cell         bank_rdata [2];

    for (genvar b = 0; b < 2; b++) begin : g_bank
        fsge_bank #(
            .ADDR_W (AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (bank_waddr[b]),
            .i_wdata (bank_wdata[b]),
            .i_raddr (bank_raddr[b]),
            .o_rdata (bank_rdata[b])
        );
    end

    // Cells arriving from the banks for the current row and the row below.
    t_cell in_cur, in_below;

    always_comb begin
        in_cur   = r_row[0] ? bank_rdata[1] : bank_rdata[0];
        in_below = r_row[0] ? bank_rdata[0] : bank_rdata[1];
        if (!in_valid) begin
            in_cur   = '0;
            in_below = '0;
        end
    end

    // Move decision for the particle in the middle of the window.
    t_nbhd      nbhd;
    t_nbhd      n_nbhd;
    t_visit_ctl ctl;
    logic       n_skip;

    always_comb begin
        nbhd.left        = r_left;
        nbhd.cur         = r_cur;
        nbhd.right       = in_cur;
        nbhd.below_left  = r_below_left;
        nbhd.below       = r_below;
        nbhd.below_right = in_below;
        ctl.cur_ok       = cur_ok;
        ctl.left_ok      = wr_en;
        ctl.right_ok     = in_valid;
        ctl.skip         = r_skip;
    end

    fsge_mover u_mover (
        .i_nbhd        (nbhd),
        .i_ctl         (ctl),
        .i_mode        (r_mode),
        .o_nbhd        (n_nbhd),
        .o_moved_right (n_skip)
    );

    // Bank port steering. During a sweep the bank holding the current row
    // sees the current row and the other bank sees the row below.
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = r_clr;
            bank_wdata[b] = '0;
            bank_raddr[b] = req_addr;
            case (r_state)
                ST_CLEAR: begin
                    bank_we[b] = 1'b1;
                end
                ST_SWEEP: begin
                    if (r_row[0] == 1'(b)) begin
                        bank_raddr[b] = {r_row[Y_W-1:1], rd_col};
                        bank_waddr[b] = {r_row[Y_W-1:1], wr_col};
                        bank_wdata[b] = n_nbhd.left;
                    end else begin
                        bank_raddr[b] = {row_below[Y_W-1:1], rd_col};
                        bank_waddr[b] = {row_below[Y_W-1:1], wr_col};
                        bank_wdata[b] = n_nbhd.below_left;
                    end
                    bank_we[b] = wr_en;
                end
                ST_IDLE: begin
                    bank_waddr[b] = req_addr;
                    bank_wdata[b] = {1'b1, i_req.color};
                    bank_we[b]    = accept && (i_req.req_type == REQ_PLACE) && req_inside
                                    && (req_y[0] == 1'(b));
                end
                default: begin
                end
            endcase
        end
    end

    // Window shift: the visited column moves left and the arriving column
    // becomes the middle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SWEEP) begin
            r_left       <= n_nbhd.cur;
            r_cur        <= n_nbhd.right;
            r_below_left <= n_nbhd.below;
            r_below      <= n_nbhd.below_right;
        end
    end

    // The read result is taken from the bank that holds the requested row.
    t_cell rd_cell;
    assign rd_cell = r_rd_bank ? bank_rdata[1] : bank_rdata[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_mode      <= MODE_SAND;
            r_clr       <= '0;
            r_owe       <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_skip      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= 1'b0;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_rsp <= '0;
                        case (i_req.req_type)
                            REQ_TICK: begin
                                r_state <= ST_SWEEP;
                                r_row   <= ROW_FIRST;
                                r_col   <= '0;
                                r_skip  <= 1'b0;
                            end
                            REQ_PLACE: begin
                                r_rsp_valid <= 1'b1;
                            end
                            REQ_CLEAR: begin
                                r_state <= ST_CLEAR;
                                r_clr   <= '0;
                                r_owe   <= 1'b1;
                            end
                            default: begin
                                r_state     <= ST_READ;
                                r_rd_bank   <= req_y[0];
                                r_rd_inside <= req_inside;
                            end
                        endcase
                    end
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state     <= ST_IDLE;
                        r_rsp_valid <= r_owe;
                        r_rsp       <= '0;
                        r_owe       <= 1'b0;
                    end
                end
                ST_SWEEP: begin
                    r_skip <= n_skip;
                    if (r_col == COL_LAST) begin
                        r_col <= '0;
                        if (r_row == '0) begin
                            r_state     <= ST_IDLE;
                            r_rsp_valid <= 1'b1;
                            r_rsp       <= '0;
                        end else begin
                            r_row <= r_row - Y_W'(1);
                        end
                    end else begin
                        r_col <= r_col + C_W'(1);
                    end
                end
                ST_READ: begin
                    r_state                <= ST_IDLE;
                    r_rsp_valid            <= 1'b1;
                    r_rsp.cell_occupied    <= r_rd_inside && rd_cell.occ;
                    r_rsp.cell_color       <= (r_rd_inside && rd_cell.occ) ?
                                              rd_cell.color : '0;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    // No result leaves while the engine is busy.
    a_no_rsp_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_rsp_valid)
        else $error("result strobe while busy");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.req_type == REQ_READ)) |-> ##2 o_rsp_valid)
        else $error("read result missing");

    // The last column step of the top row ends the tick with a result.
    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && (r_row == '0) && (r_col == COL_LAST))
        |=> (o_rsp_valid && !busy))
        else $error("tick ended without a result");

    // An empty answer never carries a color.
    a_empty_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.cell_occupied) |-> (o_rsp.cell_color == '0))
        else $error("color on an empty result");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/fsge_bank.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Falling sand grid row bank
// Simple dual-port cell memory with a registered read, one write per cycle.
// ----------------------------------------------------------------------------
module fsge_bank
    import fsge_pkg::*;
#(
    parameter int ADDR_W = BANK_AW_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_cell             i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_cell                  o_rdata
);

    t_cell r_mem [2**ADDR_W];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/fsge_mover.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Falling sand particle mover
// Decides the move of one particle from its neighborhood and the material mode.
// ----------------------------------------------------------------------------
module fsge_mover
    import fsge_pkg::*;
(
    input  wire t_nbhd      i_nbhd,
    input  wire t_visit_ctl i_ctl,
    input  wire logic [1:0] i_mode,
    output t_nbhd           o_nbhd,
    output logic            o_moved_right
);

    logic visit;

    assign visit = i_ctl.cur_ok && i_nbhd.cur.occ && !i_ctl.skip;

    always_comb begin
        o_nbhd        = i_nbhd;
        o_moved_right = 1'b0;
        if (visit) begin
            if (!i_nbhd.below.occ) begin
                o_nbhd.below = i_nbhd.cur;
                o_nbhd.cur   = '0;
            end else begin
                case (i_mode)
                    MODE_SAND: begin
                        if (i_ctl.left_ok && !i_nbhd.below_left.occ) begin
                            o_nbhd.below_left = i_nbhd.cur;
                            o_nbhd.cur        = '0;
                        end else if (i_ctl.right_ok && !i_nbhd.below_right.occ) begin
                            o_nbhd.below_right = i_nbhd.cur;
                            o_nbhd.cur         = '0;
                        end
                    end
                    MODE_WATER: begin
                        if (i_ctl.left_ok && !i_nbhd.left.occ) begin
                            o_nbhd.left = i_nbhd.cur;
                            o_nbhd.cur  = '0;
                        end else if (i_ctl.right_ok && !i_nbhd.right.occ) begin
                            o_nbhd.right  = i_nbhd.cur;
                            o_nbhd.cur    = '0;
                            o_moved_right = 1'b1;
                        end
                    end
                    default: begin
                        // Straight fall only: a blocked particle stays.
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_falling_sand_grid_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Falling sand grid engine testbench
// Drives place, clear, read and tick requests into the grid engine under all
// four material modes. A software copy of the grid predicts every result, and
// each result the engine returns is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_falling_sand_grid_engine;
    import fsge_pkg::*;

    // Mode codes that the package leaves unnamed. The spare code must behave
    // like the straight fall mode.
    localparam logic [1:0] MODE_FALL  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // No tick and no clearing pass after reset lasts this long, so this many
    // cycles with no request and no result means a hang.
    localparam int QUIET_LIMIT = 20000;

    // Number of requests after which the random part starts no new phase.
    localparam int REQUEST_GOAL = 140;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the grid, with a moved flag per
    // cell, and the material mode. Each accepted request updates that copy
    // and queues the result the engine must answer with.
    // ------------------------------------------------------------------------
    class sand_scoreboard;
        t_cell      grid  [GRID_H_DEF][GRID_W_DEF];
        bit         moved [GRID_H_DEF][GRID_W_DEF];
        logic [1:0] mode;
        t_rsp       answers_due [$];
        int         errors;
        int         reported;
        int         req_count [4];
        bit [3:0]   tick_modes;

        function new();
            wipe();
            mode       = MODE_SAND;
            errors     = 0;
            reported   = 0;
            tick_modes = '0;
            foreach (req_count[i]) req_count[i] = 0;
        endfunction

        function void wipe();
            foreach (grid[y, x]) begin
                grid[y][x]  = '0;
                moved[y][x] = 1'b0;
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("%s", msg);
            end
        endfunction

        // Moves the particle if the target is empty; the moved particle is
        // flagged so the rest of the sweep leaves it alone.
        function bit try_move(int fx, int fy, int tx, int ty);
            if (grid[ty][tx].occ) return 1'b0;
            grid[ty][tx]  = grid[fy][fx];
            moved[ty][tx] = 1'b1;
            grid[fy][fx]  = '0;
            moved[fy][fx] = 1'b0;
            return 1'b1;
        endfunction

        function void visit(int x, int y);
            if (!grid[y][x].occ || moved[y][x]) return;
            if (try_move(x, y, x, y + 1)) return;
            if (mode == MODE_SAND) begin
                if (x > 0 && try_move(x, y, x - 1, y + 1)) return;
                if (x < GRID_W_DEF - 1 && try_move(x, y, x + 1, y + 1)) return;
            end else if (mode == MODE_WATER) begin
                if (x > 0 && try_move(x, y, x - 1, y)) return;
                if (x < GRID_W_DEF - 1 && try_move(x, y, x + 1, y)) return;
            end
            // Blocked: it stays put for the rest of this sweep.
            moved[y][x] = 1'b1;
        endfunction

        // Bottom-up sweep, left to right in each row; the bottom row is never
        // visited.
        function void sweep();
            for (int y = GRID_H_DEF - 2; y >= 0; y--)
                for (int x = 0; x < GRID_W_DEF; x++)
                    visit(x, y);
            foreach (moved[y, x]) moved[y][x] = 1'b0;
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            rsp = '0;
            req_count[r.req_type]++;
            case (r.req_type)
                REQ_TICK: begin
                    sweep();
                    tick_modes[mode] = 1'b1;
                end
                REQ_PLACE: begin
                    grid[r.pos_y][r.pos_x].occ   = 1'b1;
                    grid[r.pos_y][r.pos_x].color = r.color;
                    moved[r.pos_y][r.pos_x]      = 1'b0;
                end
                REQ_CLEAR: wipe();
                REQ_READ: begin
                    if (grid[r.pos_y][r.pos_x].occ) begin
                        rsp.cell_occupied = 1'b1;
                        rsp.cell_color    = grid[r.pos_y][r.pos_x].color;
                    end
                end
            endcase
            answers_due.push_back(rsp);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (answers_due.size() == 0) begin
                flag($sformatf("ERROR: result occ=%0b color=%06h with no request open",
                               got.cell_occupied, got.cell_color));
                return;
            end
            want = answers_due.pop_front();
            if (got.cell_occupied !== want.cell_occupied)
                flag($sformatf("ERROR: cell_occupied expected %0b, got %0b",
                               want.cell_occupied, got.cell_occupied));
            if (got.cell_color !== want.cell_color)
                flag($sformatf("ERROR: cell_color expected %06h, got %06h",
                               want.cell_color, got.cell_color));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and shared state.
    // ------------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;
    logic       o_rsp_valid;
    t_rsp       o_rsp;

    sand_scoreboard sb;
    int             sent;
    int             quiet_cycles;
    bit             no_idle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    falling_sand_grid_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the inputs have
    // been stable since the falling edge. A mode write, a result and a newly
    // accepted request can share an edge; the queue keeps them in order. The
    // watchdog counts edges with neither a request accepted nor a result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.mode = i_cfg_wdata;
            if (o_rsp_valid)
                sb.check_result(o_rsp);
            if (start && !busy)
                sb.note_request(i_req);
            if (o_rsp_valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
                $display("tb_falling_sand_grid_engine: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. They are all entered and left at a falling edge. A request
    // leaves start high on return, so the next call must either present a new
    // request at once or lower start; both happen with a single assignment in
    // that time step.
    // ------------------------------------------------------------------------

    // Sender idles in about 28 of 100 requests, mostly briefly, sometimes for
    // long enough to span a whole phase of a read or a place.
    task automatic idle_gap();
        int n;
        if (no_idle || $urandom_range(99) >= 28) return;
        n = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_req(t_req r);
        idle_gap();
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic place(int x, int y, logic [COLOR_W-1:0] c);
        t_req r;
        r.req_type = REQ_PLACE;
        r.pos_x    = 6'(x);
        r.pos_y    = 6'(y);
        r.color    = c;
        send_req(r);
    endtask

    // The color field of a read is don't-care, so it carries random bits.
    task automatic read_cell(int x, int y);
        t_req r;
        r.req_type = REQ_READ;
        r.pos_x    = 6'(x);
        r.pos_y    = 6'(y);
        r.color    = COLOR_W'($urandom);
        send_req(r);
    endtask

    task automatic run_tick();
        t_req r;
        r.req_type = REQ_TICK;
        r.pos_x    = 6'($urandom);
        r.pos_y    = 6'($urandom);
        r.color    = COLOR_W'($urandom);
        send_req(r);
    endtask

    task automatic clear_grid();
        t_req r;
        r.req_type = REQ_CLEAR;
        r.pos_x    = 6'($urandom);
        r.pos_y    = 6'($urandom);
        r.color    = COLOR_W'($urandom);
        send_req(r);
    endtask

    // Holds off until every queued result has come back and the engine is no
    // longer busy. Checked at the falling edge, after the monitor has run.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0 || busy);
    endtask

    // Mode writes only happen with the engine drained.
    task automatic write_mode(logic [1:0] m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int         phase;
        int         bx, by, w, nt, nplace, nread, x0, x1, y1;
        logic [1:0] m;

        sb           = new();
        sent         = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The engine clears its store after reset; drain waits that out.
        write_mode(MODE_SAND);

        // Directed part, sand mode. An empty cell reads as zeros, then the
        // top-left and bottom-right corners are filled, including a black
        // particle that must still read as occupied, and a place over an
        // existing particle.
        read_cell(0, 0);
        place(0, 0, 24'hFFFFFF);
        read_cell(0, 0);
        place(63, 63, 24'h000000);
        read_cell(63, 63);
        place(63, 63, 24'hA5A5A5);
        read_cell(63, 63);

        // Edge columns: a particle sitting on another at the left edge can only
        // slide right, one at the right edge only left. The bottom row stays.
        place(0, 63, 24'h123456);
        place(0, 62, 24'hABCDEF);
        place(63, 62, 24'h654321);
        run_tick();
        read_cell(0, 1);
        read_cell(1, 63);
        read_cell(62, 63);
        read_cell(63, 63);
        read_cell(0, 63);

        // A two-high stack falls together, each by one row.
        place(5, 10, 24'h800001);
        place(5, 11, 24'h7FFFFE);
        run_tick();
        read_cell(5, 11);
        read_cell(5, 12);

        // Clear empties everything.
        clear_grid();
        read_cell(1, 63);
        read_cell(5, 12);

        // Random part. Each phase picks a mode, drops a cluster of particles
        // into a small window, mostly near the floor so they pile up, runs a few
        // ticks and reads back the window and one column on each side, down to the
        // lowest reachable row. A share of requests is noise anywhere on the grid.
        phase = 0;
        while (sent < REQUEST_GOAL) begin
            case (phase % 5)
                0:       m = MODE_WATER;
                1:       m = MODE_FALL;
                2:       m = MODE_SPARE;
                3:       m = MODE_SAND;
                default: m = 2'($urandom_range(3));
            endcase
            write_mode(m);
            // One whole phase runs with the sender never idling.
            no_idle = (phase == 2);

            if ($urandom_range(2) == 0)
                clear_grid();

            w  = $urandom_range(2, 6);
            case ($urandom_range(2))
                0:       bx = 0;
                1:       bx = 64 - w;
                default: bx = $urandom_range(0, 64 - w);
            endcase
            by = ($urandom_range(9) < 7) ? $urandom_range(52, 60) : $urandom_range(0, 60);

            nplace = $urandom_range(5, 10);
            for (int i = 0; i < nplace; i++) begin
                if ($urandom_range(99) < 20) begin
                    if ($urandom_range(1))
                        place($urandom_range(63), $urandom_range(63), COLOR_W'($urandom));
                    else
                        read_cell($urandom_range(63), $urandom_range(63));
                end else begin
                    place(bx + $urandom_range(0, w - 1), by + $urandom_range(0, 3),
                          COLOR_W'($urandom));
                end
            end

            nt = $urandom_range(1, 3);
            for (int i = 0; i < nt; i++)
                run_tick();

            // Once, the sender also waits for everything to come back before
            // reading, so reads start on an idle engine.
            if (phase == 1)
                drain();

            x0    = (bx > 0) ? bx - 1 : 0;
            x1    = (bx + w < 64) ? bx + w : 63;
            y1    = (by + 3 + nt < 64) ? by + 3 + nt : 63;
            nread = $urandom_range(5, 9);
            for (int i = 0; i < nread; i++)
                read_cell($urandom_range(x0, x1), $urandom_range(by, y1));

            phase++;
        end

        // Wait for the last result, then a short settle to catch strays.
        drain();
        repeat (10) @(negedge i_clk);

        $display("Ran %0d requests: %0d ticks, %0d places, %0d clears, %0d reads.",
                 sent, sb.req_count[REQ_TICK], sb.req_count[REQ_PLACE],
                 sb.req_count[REQ_CLEAR], sb.req_count[REQ_READ]);
        $display("Ticks covered mode mask %b; %0d errors, %0d results still owed.",
                 sb.tick_modes, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_falling_sand_grid_engine: PASS");
        else
            $display("tb_falling_sand_grid_engine: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
